>>> rtl/lhwc_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lhwc_pkg
// Types and constants shared by the layer hit window coincidence unit.
// ---------------------------------------------------------------------------
package lhwc_pkg;

  // request codes on in_data.req_type
  localparam logic [1:0] REQ_HIT       = 2'd0;
  localparam logic [1:0] REQ_HIT_CLOSE = 2'd1;
  localparam logic [1:0] REQ_CLOSE     = 2'd2;

  // configuration register indexes
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_EXCL_MASK = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_GOOD_LOW  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_GOOD_HIGH = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_OK_LOW    = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_OK_HIGH   = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_ALL_HIGH  = 3'd5;

  localparam int MASK_W = 9;

  // register reset values
  localparam logic [MASK_W-1:0]  RST_EXCL_MASK = 9'd33;
  localparam logic signed [15:0] RST_GOOD_LOW  = 16'sd368;
  localparam logic signed [15:0] RST_GOOD_HIGH = 16'sd3472;
  localparam logic signed [15:0] RST_OK_LOW    = 16'sd80;
  localparam logic signed [15:0] RST_OK_HIGH   = 16'sd3472;
  localparam logic signed [15:0] RST_ALL_HIGH  = 16'sd7200;

  localparam logic [1:0] LAYER_CNT_MAX = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         layer;
    logic signed [15:0] drift_time;
  } in_item_t;

  typedef struct packed {
    logic [3:0] good_pairs;
    logic [3:0] ok_pairs;
    logic [3:0] all_pairs;
    logic [3:0] layers_one_good;
    logic [3:0] layers_one_ok;
    logic [3:0] layers_one_any;
    logic [3:0] layers_crowded;
    logic [7:0] hits_good;
    logic [7:0] hits_ok;
    logic [7:0] hits_in_window;
    logic [7:0] hits_unmasked;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic hit_en;      // apply the accepted hit to the store
    logic scan_start;  // zero scan index and summary accumulators
    logic scan_step;   // fold one layer into the summary
    logic load_out;    // capture summary into the output register, clear store
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;   // scan index sits on the last layer
  } dp_sts_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } ctl_state_t;

endpackage : lhwc_pkg
`default_nettype wire

>>> rtl/lhwc_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lhwc_ctrl
// Sequencer: takes beats, runs the per-layer scan at event close and owns
// the output valid.
// ---------------------------------------------------------------------------
module lhwc_ctrl
  import lhwc_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic [1:0] req_type,
  output logic          out_valid,
  input  wire logic     out_ready,
  output dp_cmd_t       cmd,
  input  wire dp_sts_t  sts
);

  ctl_state_t st_r, st_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       acc_in;
  logic       slot_free;

  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign acc_in    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    st_nxt = st_r;
    cmd    = '0;
    case (st_r)
      S_IDLE: begin
        if (acc_in) begin
          case (req_type)
            REQ_HIT: begin
              cmd.hit_en = 1'b1;
            end
            REQ_HIT_CLOSE: begin
              cmd.hit_en     = 1'b1;
              cmd.scan_start = 1'b1;
              st_nxt         = S_SCAN;
            end
            REQ_CLOSE: begin
              cmd.scan_start = 1'b1;
              st_nxt         = S_SCAN;
            end
            default: ;  // unused code: no effect
          endcase
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          st_nxt       = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_SCAN && sts.scan_last) |=> (st_r == S_DONE))
    else $error("scan did not finish after last layer");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken one");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid_r)
    else $error("loaded result not presented");

  a_close_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && (req_type == REQ_HIT_CLOSE || req_type == REQ_CLOSE)) |=> (st_r == S_SCAN))
    else $error("event close did not start a scan");

endmodule : lhwc_ctrl
`default_nettype wire

>>> rtl/lhwc_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lhwc_datapath
// Config registers, window compares, per-layer and total counters, the
// layer-serial summary scan and the output register.
// ---------------------------------------------------------------------------
module lhwc_datapath
  import lhwc_pkg::*;
#(
  parameter int NUM_LAYERS     = 9,
  parameter int HIT_COUNT_BITS = 8
)(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire in_item_t              in_data,
  input  wire dp_cmd_t               cmd,
  output dp_sts_t                    sts,
  output out_item_t                  out_data
);

  localparam int LIDX_W = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
  localparam int EXT_W  = (HIT_COUNT_BITS > 8) ? HIT_COUNT_BITS : 8;
  localparam logic [HIT_COUNT_BITS-1:0] TOT_MAX = '1;

  // config
  logic [MASK_W-1:0]  excl_mask_r;
  logic signed [15:0] good_low_r, good_high_r, ok_low_r, ok_high_r, all_high_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      excl_mask_r <= RST_EXCL_MASK;
      good_low_r  <= RST_GOOD_LOW;
      good_high_r <= RST_GOOD_HIGH;
      ok_low_r    <= RST_OK_LOW;
      ok_high_r   <= RST_OK_HIGH;
      all_high_r  <= RST_ALL_HIGH;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_EXCL_MASK: excl_mask_r <= cfg_wdata[MASK_W-1:0];
        CFG_GOOD_LOW:  good_low_r  <= cfg_wdata;
        CFG_GOOD_HIGH: good_high_r <= cfg_wdata;
        CFG_OK_LOW:    ok_low_r    <= cfg_wdata;
        CFG_OK_HIGH:   ok_high_r   <= cfg_wdata;
        CFG_ALL_HIGH:  all_high_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // hit classification
  logic              layer_in_range, layer_masked, hit_take;
  logic              is_good, is_ok, is_all;
  logic [LIDX_W-1:0] hit_idx;

  assign layer_in_range = 32'(in_data.layer) < 32'(NUM_LAYERS);
  assign layer_masked   = (32'(in_data.layer) < 32'(MASK_W)) && excl_mask_r[in_data.layer];
  assign hit_take       = cmd.hit_en && layer_in_range && !layer_masked;
  assign hit_idx        = LIDX_W'(in_data.layer);

  assign is_good = (in_data.drift_time > good_low_r) && (in_data.drift_time < good_high_r);
  assign is_ok   = (in_data.drift_time > ok_low_r)   && (in_data.drift_time < ok_high_r);
  assign is_all  = (in_data.drift_time > ok_low_r)   && (in_data.drift_time < all_high_r);

  // per-layer store and totals
  logic [1:0] good_cnt_r [NUM_LAYERS];
  logic [1:0] ok_cnt_r   [NUM_LAYERS];
  logic [1:0] any_cnt_r  [NUM_LAYERS];
  logic [HIT_COUNT_BITS-1:0] tot_good_r, tot_ok_r, tot_all_r, tot_unm_r;
  logic [LIDX_W-1:0] scan_idx_r;
  logic [LIDX_W-1:0] rd_idx;
  logic [1:0]        rd_good, rd_ok, rd_any;

  // single read port: hit address while idle, scan address while scanning
  assign rd_idx  = cmd.scan_step ? scan_idx_r : hit_idx;
  assign rd_good = good_cnt_r[rd_idx];
  assign rd_ok   = ok_cnt_r[rd_idx];
  assign rd_any  = any_cnt_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load_out) begin
      for (int i = 0; i < NUM_LAYERS; i++) begin
        good_cnt_r[i] <= '0;
        ok_cnt_r[i]   <= '0;
        any_cnt_r[i]  <= '0;
      end
      tot_good_r <= '0;
      tot_ok_r   <= '0;
      tot_all_r  <= '0;
      tot_unm_r  <= '0;
    end else if (hit_take) begin
      if (is_good && rd_good != LAYER_CNT_MAX) good_cnt_r[hit_idx] <= rd_good + 2'd1;
      if (is_ok && rd_ok != LAYER_CNT_MAX)     ok_cnt_r[hit_idx]   <= rd_ok + 2'd1;
      if (is_all && rd_any != LAYER_CNT_MAX)   any_cnt_r[hit_idx]  <= rd_any + 2'd1;
      if (is_good && tot_good_r != TOT_MAX) tot_good_r <= tot_good_r + 1'b1;
      if (is_ok && tot_ok_r != TOT_MAX)     tot_ok_r   <= tot_ok_r + 1'b1;
      if (is_all && tot_all_r != TOT_MAX)   tot_all_r  <= tot_all_r + 1'b1;
      if (tot_unm_r != TOT_MAX)             tot_unm_r  <= tot_unm_r + 1'b1;
    end
  end

  // layer-serial summary scan
  logic       cur_g1, cur_o1, cur_a1, cur_crowd;
  logic       prev_g1_r, prev_o1_r, prev_a1_r;
  logic [3:0] gp_r, op_r, ap_r, g1_r, o1_r, a1_r, crowd_r;

  assign cur_g1    = (rd_good == 2'd1);
  assign cur_o1    = (rd_ok == 2'd1);
  assign cur_a1    = (rd_any == 2'd1);
  assign cur_crowd = (rd_any == LAYER_CNT_MAX);
  assign sts.scan_last = (32'(scan_idx_r) == 32'(NUM_LAYERS - 1));

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx_r <= '0;
      prev_g1_r  <= 1'b0;
      prev_o1_r  <= 1'b0;
      prev_a1_r  <= 1'b0;
      gp_r <= '0; op_r <= '0; ap_r <= '0;
      g1_r <= '0; o1_r <= '0; a1_r <= '0; crowd_r <= '0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + 1'b1;
      prev_g1_r  <= cur_g1;
      prev_o1_r  <= cur_o1;
      prev_a1_r  <= cur_a1;
      gp_r    <= gp_r + 4'(prev_g1_r && cur_g1);
      op_r    <= op_r + 4'(prev_o1_r && cur_o1);
      ap_r    <= ap_r + 4'(prev_a1_r && cur_a1);
      g1_r    <= g1_r + 4'(cur_g1);
      o1_r    <= o1_r + 4'(cur_o1);
      a1_r    <= a1_r + 4'(cur_a1);
      crowd_r <= crowd_r + 4'(cur_crowd);
    end
  end

  // output register
  logic [EXT_W-1:0] ext_good, ext_ok, ext_all, ext_unm;
  out_item_t        out_r;

  assign ext_good = EXT_W'(tot_good_r);
  assign ext_ok   = EXT_W'(tot_ok_r);
  assign ext_all  = EXT_W'(tot_all_r);
  assign ext_unm  = EXT_W'(tot_unm_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.good_pairs      <= gp_r;
      out_r.ok_pairs        <= op_r;
      out_r.all_pairs       <= ap_r;
      out_r.layers_one_good <= g1_r;
      out_r.layers_one_ok   <= o1_r;
      out_r.layers_one_any  <= a1_r;
      out_r.layers_crowded  <= crowd_r;
      out_r.hits_good       <= ext_good[7:0];
      out_r.hits_ok         <= ext_ok[7:0];
      out_r.hits_in_window  <= ext_all[7:0];
      out_r.hits_unmasked   <= ext_unm[7:0];
    end
  end

  assign out_data = out_r;

endmodule : lhwc_datapath
`default_nettype wire

>>> rtl/layer_hit_window_coincidence_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// layer_hit_window_coincidence_unit
// Drift-chamber event summary: classifies hits by time window, counts them
// per layer and in total, and reports single-hit and coincidence counts at
// event close.
// ---------------------------------------------------------------------------
//
//  channel  ports                          beat
//  -------  -----------------------------  ---------------------------------
//  in       in_valid/in_ready/in_data      one hit and/or event close
//  out      out_valid/out_ready/out_data   one event summary
//  cfg      cfg_we/cfg_addr/cfg_wdata      one register write, no wait
//
//  A hit beat is handled in place (compare + counter bump).
//  A closing beat runs through the accept, the summary scan over the layers,
//  one layer at a time (one store read port shared with hits), and the load
//  of the output register, which also clears the store.
//  Hits keep flowing while a summary waits in the output register; only the
//  load at the end of the next close stalls on out_ready.
//  Reset (rst_n low, synchronous) restores config defaults, clears store.
//
module layer_hit_window_coincidence_unit
  import lhwc_pkg::*;
#(
  parameter int NUM_LAYERS     = 9,
  parameter int HIT_COUNT_BITS = 8
)(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // hit stream
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  // event summaries
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  // register writes
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: decides per cycle what the datapath does
  lhwc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (in_data.req_type),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // counters, windows, scan accumulators and output register
  lhwc_datapath #(
    .NUM_LAYERS     (NUM_LAYERS),
    .HIT_COUNT_BITS (HIT_COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule : layer_hit_window_coincidence_unit
`default_nettype wire

>>> verif/event_summary_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// event_summary_checker
// Watches the hit, summary and register ports of the coincidence unit. Keeps
// its own copy of the window settings and of the per-layer store, works out
// each event summary at close, and compares every summary beat field by field.
// ---------------------------------------------------------------------------
module event_summary_checker
  import lhwc_pkg::*;
#(
  parameter int NUM_LAYERS     = 9,
  parameter int HIT_COUNT_BITS = 8
)(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending,
  output int                    checked
);

  logic [MASK_W-1:0]         skip_mask;
  logic signed [15:0]        good_lo, good_hi, ok_lo, ok_hi, any_hi;
  logic [1:0]                good_cnt [NUM_LAYERS];
  logic [1:0]                ok_cnt   [NUM_LAYERS];
  logic [1:0]                any_cnt  [NUM_LAYERS];
  logic [HIT_COUNT_BITS-1:0] n_good, n_ok, n_any, n_seen;
  out_item_t                 expected_summaries [$];
  out_item_t                 want;

  function automatic logic [1:0] bump_layer(logic [1:0] c);
    return (c == LAYER_CNT_MAX) ? c : c + 2'd1;
  endfunction

  function automatic logic [HIT_COUNT_BITS-1:0] bump_total(logic [HIT_COUNT_BITS-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  task automatic clear_store();
    for (int l = 0; l < NUM_LAYERS; l++) begin
      good_cnt[l] = '0;
      ok_cnt[l]   = '0;
      any_cnt[l]  = '0;
    end
    n_good = '0;
    n_ok   = '0;
    n_any  = '0;
    n_seen = '0;
  endtask

  task automatic tally_hit(in_item_t b);
    logic signed [15:0] t;
    int                 l;
    t = b.drift_time;
    l = b.layer;
    if (l >= NUM_LAYERS || skip_mask[l]) return;
    if (t > good_lo && t < good_hi) begin
      good_cnt[l] = bump_layer(good_cnt[l]);
      n_good      = bump_total(n_good);
    end
    if (t > ok_lo && t < ok_hi) begin
      ok_cnt[l] = bump_layer(ok_cnt[l]);
      n_ok      = bump_total(n_ok);
    end
    if (t > ok_lo && t < any_hi) begin
      any_cnt[l] = bump_layer(any_cnt[l]);
      n_any      = bump_total(n_any);
    end
    n_seen = bump_total(n_seen);
  endtask

  task automatic close_event();
    out_item_t s;
    s = '0;
    for (int l = 0; l < NUM_LAYERS; l++) begin
      if (good_cnt[l] == 2'd1) s.layers_one_good = s.layers_one_good + 4'd1;
      if (ok_cnt[l] == 2'd1)   s.layers_one_ok   = s.layers_one_ok + 4'd1;
      if (any_cnt[l] == 2'd1)  s.layers_one_any  = s.layers_one_any + 4'd1;
      if (any_cnt[l] == LAYER_CNT_MAX) s.layers_crowded = s.layers_crowded + 4'd1;
      if (l + 1 < NUM_LAYERS) begin
        if (good_cnt[l] == 2'd1 && good_cnt[l+1] == 2'd1) s.good_pairs = s.good_pairs + 4'd1;
        if (ok_cnt[l] == 2'd1 && ok_cnt[l+1] == 2'd1)     s.ok_pairs   = s.ok_pairs + 4'd1;
        if (any_cnt[l] == 2'd1 && any_cnt[l+1] == 2'd1)   s.all_pairs  = s.all_pairs + 4'd1;
      end
    end
    s.hits_good      = 8'(n_good);
    s.hits_ok        = 8'(n_ok);
    s.hits_in_window = 8'(n_any);
    s.hits_unmasked  = 8'(n_seen);
    expected_summaries.push_back(s);
    clear_store();
  endtask

  task automatic report_mismatch(string msg);
    fail_count++;
    $display("%0t checker: %s", $time, msg);
  endtask

  task automatic check_field(string name, int got, int wanted);
    if (got != wanted)
      report_mismatch($sformatf("summary %0d: %s is %0d, expected %0d",
                                checked, name, got, wanted));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      skip_mask = RST_EXCL_MASK;
      good_lo   = RST_GOOD_LOW;
      good_hi   = RST_GOOD_HIGH;
      ok_lo     = RST_OK_LOW;
      ok_hi     = RST_OK_HIGH;
      any_hi    = RST_ALL_HIGH;
      clear_store();
      expected_summaries.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_EXCL_MASK: skip_mask = cfg_wdata[MASK_W-1:0];
          CFG_GOOD_LOW:  good_lo   = cfg_wdata;
          CFG_GOOD_HIGH: good_hi   = cfg_wdata;
          CFG_OK_LOW:    ok_lo     = cfg_wdata;
          CFG_OK_HIGH:   ok_hi     = cfg_wdata;
          CFG_ALL_HIGH:  any_hi    = cfg_wdata;
          default: ;
        endcase
      end
      // summary side first: a summary can never leave on its own closing beat
      if (out_valid && out_ready) begin
        if (expected_summaries.size() == 0) begin
          report_mismatch("summary beat with no event closed");
        end else begin
          want = expected_summaries.pop_front();
          check_field("good_pairs", out_data.good_pairs, want.good_pairs);
          check_field("ok_pairs", out_data.ok_pairs, want.ok_pairs);
          check_field("all_pairs", out_data.all_pairs, want.all_pairs);
          check_field("layers_one_good", out_data.layers_one_good, want.layers_one_good);
          check_field("layers_one_ok", out_data.layers_one_ok, want.layers_one_ok);
          check_field("layers_one_any", out_data.layers_one_any, want.layers_one_any);
          check_field("layers_crowded", out_data.layers_crowded, want.layers_crowded);
          check_field("hits_good", out_data.hits_good, want.hits_good);
          check_field("hits_ok", out_data.hits_ok, want.hits_ok);
          check_field("hits_in_window", out_data.hits_in_window, want.hits_in_window);
          check_field("hits_unmasked", out_data.hits_unmasked, want.hits_unmasked);
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        case (in_data.req_type)
          REQ_HIT:       tally_hit(in_data);
          REQ_HIT_CLOSE: begin
            tally_hit(in_data);
            close_event();
          end
          REQ_CLOSE:     close_event();
          default: ;
        endcase
      end
    end
    pending = expected_summaries.size();
  end

endmodule : event_summary_checker

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the layer hit window coincidence unit: a directed set of
// boundary and special-case events, then random events under a series of
// window and mask settings, with random idling on both channels. Checking
// lives in event_summary_checker.
// ---------------------------------------------------------------------------
module tb_top;
  import lhwc_pkg::*;

  localparam int NUM_LAYERS     = 9;
  localparam int HIT_COUNT_BITS = 8;
  localparam int NUM_PHASES     = 7;
  localparam int PHASE_BEATS    = 200;   // beats sent per quota phase
  localparam int SAT_HITS       = 300;   // one long event drives totals past 255
  // worst quiet stretch of a correct run: close scan + output stall +
  // drain pause + 6 cfg writes; limit is that many times over
  localparam int QUIET_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = NUM_LAYERS + 4;
  // code 3 has no meaning to the block; sent as noise
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int n_fail, n_pending, n_checked;
  int win [0:5];        // current register settings, indexed by register
  bit idle_on;          // random idling enabled on both channels
  int n_beats, n_ignored, n_settings;
  int quiet_cycles = 0;
  int stall_left = 0;

  layer_hit_window_coincidence_unit #(
    .NUM_LAYERS     (NUM_LAYERS),
    .HIT_COUNT_BITS (HIT_COUNT_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  event_summary_checker #(
    .NUM_LAYERS     (NUM_LAYERS),
    .HIT_COUNT_BITS (HIT_COUNT_BITS)
  ) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .fail_count (n_fail),
    .pending    (n_pending),
    .checked    (n_checked)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog: any beat on either channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("tb_top: no beat moved for %0d cycles", QUIET_LIMIT);
    $display("tb_top: FAIL");
    $finish;
  end

  // summary side back-pressure: random-length stalls while idling is on
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (rst_n && idle_on && $urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic int rnd16();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic in_item_t mk(logic [1:0] rq, int ly, int t);
    in_item_t it;
    it.req_type   = rq;
    it.layer      = 4'(ly);
    it.drift_time = 16'(t);
    return it;
  endfunction

  // mostly real layers, sometimes past the last one
  function automatic int pick_layer();
    if ($urandom_range(0, 7) == 0) return $urandom_range(NUM_LAYERS, 15);
    return $urandom_range(0, NUM_LAYERS - 1);
  endfunction

  // drift time: full range, at or near a window bound, or across the windows
  function automatic int pick_time();
    int lo, hi;
    case ($urandom_range(0, 9))
      0, 1:    return rnd16();
      2, 3, 4: return win[$urandom_range(1, 5)] + int'($urandom_range(0, 4)) - 2;
      default: begin
        lo = win[CFG_GOOD_LOW];
        hi = win[CFG_GOOD_LOW];
        for (int i = 2; i <= 5; i++) begin
          if (win[i] < lo) lo = win[i];
          if (win[i] > hi) hi = win[i];
        end
        return lo + int'($urandom_range(0, hi - lo));
      end
    endcase
  endfunction

  // strictly inside the good window when it is open
  function automatic int good_time();
    if (win[CFG_GOOD_HIGH] - win[CFG_GOOD_LOW] >= 2)
      return win[CFG_GOOD_LOW] + 1 +
             int'($urandom_range(0, win[CFG_GOOD_HIGH] - win[CFG_GOOD_LOW] - 2));
    return pick_time();
  endfunction

  // one beat; called and returns at a falling edge
  task automatic send(in_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    // beats the block drops on the floor are tallied apart
    if (it.req_type == REQ_UNUSED ||
        (it.req_type == REQ_HIT &&
         (it.layer >= NUM_LAYERS || win[CFG_EXCL_MASK][it.layer])))
      n_ignored++;
    else
      n_beats++;
  endtask

  // wait for every summary, then a drain pause with the input idle
  task automatic settle();
    in_valid <= 1'b0;
    do @(negedge clk); while (n_pending != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_setup();
    for (int i = 0; i <= int'(CFG_ALL_HIGH); i++) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= CFG_ADDR_W'(i);
      cfg_wdata <= CFG_DATA_W'(win[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic random_windows();
    win[CFG_EXCL_MASK] = $urandom_range(0, 511);
    if ($urandom_range(0, 3) == 0) begin
      // anything goes, inverted windows included
      for (int i = 1; i <= 5; i++) win[i] = rnd16();
    end else begin
      win[CFG_OK_LOW]    = int'($urandom_range(0, 4000)) - 2000;
      win[CFG_GOOD_LOW]  = win[CFG_OK_LOW] + int'($urandom_range(0, 600));
      win[CFG_GOOD_HIGH] = win[CFG_GOOD_LOW] + int'($urandom_range(0, 3000));
      win[CFG_OK_HIGH]   = win[CFG_GOOD_HIGH] + int'($urandom_range(0, 200)) - 100;
      win[CFG_ALL_HIGH]  = win[CFG_OK_HIGH] + int'($urandom_range(0, 4000));
    end
  endtask

  // one event: a straight track, a scattered event, or stray noise that
  // leaves the event open into the next one
  task automatic run_event();
    int kind, first, last;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      first = $urandom_range(0, NUM_LAYERS - 1);
      last  = $urandom_range(first, NUM_LAYERS - 1);
      for (int l = first; l < last; l++) send(mk(REQ_HIT, l, good_time()));
      if ($urandom_range(0, 1)) begin
        send(mk(REQ_HIT_CLOSE, last, good_time()));
      end else begin
        send(mk(REQ_HIT, last, good_time()));
        send(mk(REQ_CLOSE, $urandom_range(0, 15), rnd16()));
      end
    end else if (kind < 9) begin
      repeat ($urandom_range(0, 12)) begin
        if ($urandom_range(0, 19) == 0) send(mk(REQ_UNUSED, pick_layer(), rnd16()));
        else send(mk(REQ_HIT, pick_layer(), pick_time()));
      end
      if ($urandom_range(0, 1)) send(mk(REQ_HIT_CLOSE, pick_layer(), pick_time()));
      else send(mk(REQ_CLOSE, $urandom_range(0, 15), rnd16()));
    end else begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 1)) send(mk(REQ_UNUSED, $urandom_range(0, 15), rnd16()));
        else send(mk(REQ_HIT, $urandom_range(NUM_LAYERS, 15), rnd16()));
      end
    end
  endtask

  initial begin
    int goal;
    win[CFG_EXCL_MASK] = RST_EXCL_MASK;
    win[CFG_GOOD_LOW]  = RST_GOOD_LOW;
    win[CFG_GOOD_HIGH] = RST_GOOD_HIGH;
    win[CFG_OK_LOW]    = RST_OK_LOW;
    win[CFG_OK_HIGH]   = RST_OK_HIGH;
    win[CFG_ALL_HIGH]  = RST_ALL_HIGH;
    idle_on = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed, at reset settings (layers 0 and 5 masked) ---
    send(mk(REQ_CLOSE, 15, -1));             // empty event, junk fields
    send(mk(REQ_HIT, 1, 369));               // just inside good
    send(mk(REQ_HIT, 2, 368));               // on good low bound: ok/all only
    send(mk(REQ_HIT, 3, 3472));              // on ok high bound: all only
    send(mk(REQ_HIT, 4, 7200));              // on all high bound: noise
    send(mk(REQ_HIT, 4, 80));                // on ok low bound: noise
    send(mk(REQ_HIT, 0, 1000));              // masked layer
    send(mk(REQ_HIT, 9, 1000));              // first layer past the end
    send(mk(REQ_HIT, 15, -32768));           // top layer code, min time
    send(mk(REQ_HIT, 6, 32767));             // max time
    send(mk(REQ_HIT, 7, -32768));
    send(mk(REQ_UNUSED, 8, 1000));           // unused request code
    send(mk(REQ_HIT, 8, 7199));              // just inside all
    send(mk(REQ_HIT_CLOSE, 5, 1000));        // closing hit on masked layer
    repeat (3) send(mk(REQ_HIT, 2, 500));    // crowded layer
    send(mk(REQ_HIT, 3, 3471));
    send(mk(REQ_HIT, 4, 81));
    send(mk(REQ_HIT, 6, 369));
    send(mk(REQ_HIT_CLOSE, 7, 369));         // closing hit makes a pair
    send(mk(REQ_HIT_CLOSE, 8, 32767));       // closing hit that is noise
    send(mk(REQ_UNUSED, 0, 0));
    send(mk(REQ_CLOSE, 0, 0));
    settle();

    // --- random events over a run of settings ---
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin                              // widest windows, nothing masked
          win[CFG_EXCL_MASK] = 0;
          win[CFG_GOOD_LOW]  = -32768;
          win[CFG_GOOD_HIGH] = 32767;
          win[CFG_OK_LOW]    = -32768;
          win[CFG_OK_HIGH]   = 32767;
          win[CFG_ALL_HIGH]  = 32767;
        end
        1: begin                              // every layer masked
          random_windows();
          win[CFG_EXCL_MASK] = 511;
        end
        2: begin                              // all windows empty
          win[CFG_EXCL_MASK] = $urandom_range(0, 511);
          win[CFG_GOOD_LOW]  = 500;
          win[CFG_GOOD_HIGH] = 500;
          win[CFG_OK_LOW]    = 32767;
          win[CFG_OK_HIGH]   = -32768;
          win[CFG_ALL_HIGH]  = -32768;
        end
        NUM_PHASES - 1: begin                 // back to reset values
          win[CFG_EXCL_MASK] = RST_EXCL_MASK;
          win[CFG_GOOD_LOW]  = RST_GOOD_LOW;
          win[CFG_GOOD_HIGH] = RST_GOOD_HIGH;
          win[CFG_OK_LOW]    = RST_OK_LOW;
          win[CFG_OK_HIGH]   = RST_OK_HIGH;
          win[CFG_ALL_HIGH]  = RST_ALL_HIGH;
        end
        default: random_windows();
      endcase
      load_setup();
      // one middle phase and the closing one run without idling
      idle_on = (ph != 3) && (ph != NUM_PHASES - 1);
      if (ph == 1) begin
        // masked hits count for nothing, so run a fixed number of events
        repeat (25) run_event();
      end else begin
        goal = n_beats + n_ignored + PHASE_BEATS;
        if (ph == 0) begin
          repeat (SAT_HITS) send(mk(REQ_HIT, $urandom_range(0, NUM_LAYERS - 1), pick_time()));
          send(mk(REQ_CLOSE, 0, 0));
        end
        while (n_beats + n_ignored < goal) run_event();
      end
      settle();
    end

    $display("tb_top: %0d hit/close beats, %0d ignored beats, %0d register settings",
             n_beats, n_ignored, n_settings);
    $display("tb_top: %0d event summaries compared, incl. a %0d-hit saturating event",
             n_checked, SAT_HITS);
    if (n_fail == 0 && n_pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule : tb_top

>>> sim.f
rtl/lhwc_pkg.sv
rtl/lhwc_ctrl.sv
rtl/lhwc_datapath.sv
rtl/layer_hit_window_coincidence_unit.sv
verif/event_summary_checker.sv
verif/tb_top.sv
